// ----- rtl/mepc_pkg.sv -----
package mepc_pkg;

    localparam int unsigned TABLE_DEPTH = 1024;
    localparam int unsigned COMP_W      = 20;
    localparam int unsigned EDGE_W      = 32;
    localparam int unsigned WEIGHT_W    = 31;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned PADDR_W     = 3;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Register select taken from paddr bit 2.
    localparam logic REG_COMP_BASE = 1'b0;
    localparam logic REG_EDGE_BASE = 1'b1;

    typedef struct packed {
        logic                used;
        logic [COMP_W-1:0]   target;
        logic [EDGE_W-1:0]   edge_id;
        logic [WEIGHT_W-1:0] weight;
    } t_entry;

    typedef struct packed {
        logic                op;
        logic                range_err;
        logic                self_loop;
        logic [COMP_W-1:0]   dst;
        logic [WEIGHT_W-1:0] weight;
        logic [EDGE_W-1:0]   edge_id;
    } t_item;

    typedef struct packed {
        logic                kept;
        logic                range_error;
        logic                entry_valid;
        logic [COMP_W-1:0]   best_target;
        logic [EDGE_W-1:0]   best_edge;
        logic [WEIGHT_W-1:0] best_weight;
    } t_result;

endpackage

// ----- rtl/mepc_table.sv -----
module mepc_table #(
    parameter int unsigned DEPTH = mepc_pkg::TABLE_DEPTH,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  mepc_pkg::t_entry i_wr_data,
    output mepc_pkg::t_entry o_rd_data,
    output logic            o_clearing
);

    mepc_pkg::t_entry mem [DEPTH];

    mepc_pkg::t_entry r_rdata;
    mepc_pkg::t_entry r_fwd_data;
    logic             r_fwd_hit;
    logic             r_clear;
    logic [AW-1:0]    r_clr_addr;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    mepc_pkg::t_entry mem_wdata;

    always_comb begin
        if (r_clear) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = i_wr_en;
            mem_waddr = i_wr_addr;
            mem_wdata = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= mem[i_rd_addr];
        end
    end

    // A write in the same cycle as the read of that entry bypasses the array.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear    <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clear) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clear <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_rd_data  = r_fwd_hit ? r_fwd_data : r_rdata;
    assign o_clearing = r_clear;

endmodule

// ----- rtl/mepc_update.sv -----
module mepc_update (
    input  mepc_pkg::t_item   i_item,
    input  mepc_pkg::t_entry  i_entry,
    output mepc_pkg::t_result o_result,
    output logic              o_wr_en,
    output mepc_pkg::t_entry  o_wr_data
);

    always_comb begin
        o_result  = '0;
        o_wr_en   = 1'b0;
        o_wr_data = '0;
        if (i_item.range_err) begin
            o_result.range_error = 1'b1;
        end else if (i_item.op == mepc_pkg::OP_OFFER) begin
            if (!i_item.self_loop) begin
                o_result.kept = 1'b1;
                if (!i_entry.used || (i_item.weight < i_entry.weight)) begin
                    o_wr_en           = 1'b1;
                    o_wr_data.used    = 1'b1;
                    o_wr_data.target  = i_item.dst;
                    o_wr_data.edge_id = i_item.edge_id;
                    o_wr_data.weight  = i_item.weight;
                end
            end
        end else begin
            if (i_entry.used) begin
                o_result.entry_valid = 1'b1;
                o_result.best_target = i_entry.target;
                o_result.best_edge   = i_entry.edge_id;
                o_result.best_weight = i_entry.weight;
            end
            o_wr_en = 1'b1;
        end
    end

endmodule

// ----- rtl/min_edge_per_component.sv -----
// An input word is registered in r_item, then its result in r_out when the output
// is free. Throughput: one word per cycle while the output is not stalled, set by
// the single table read port; a write-back to the entry read in the same cycle is
// forwarded around the memory. Reset is synchronous and active low. After reset the
// table clears itself, holding o_in_stall high; configuration writes are taken.
module min_edge_per_component #(
    parameter int unsigned TABLE_DEPTH = mepc_pkg::TABLE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [mepc_pkg::COMP_W-1:0]     i_src_comp,
    input  logic [mepc_pkg::COMP_W-1:0]     i_dst_comp,
    input  logic [mepc_pkg::WEIGHT_W-1:0]   i_weight,
    input  logic [mepc_pkg::EDGE_W-1:0]     i_edge_index,

    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_kept,
    output logic                            o_range_error,
    output logic                            o_entry_valid,
    output logic [mepc_pkg::COMP_W-1:0]     o_best_target,
    output logic [mepc_pkg::EDGE_W-1:0]     o_best_edge,
    output logic [mepc_pkg::WEIGHT_W-1:0]   o_best_weight,

    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [mepc_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [mepc_pkg::DATA_W-1:0]     i_pwdata,
    output logic [mepc_pkg::DATA_W-1:0]     o_prdata,
    output logic                            o_pready
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned DW = mepc_pkg::COMP_W + 1;
    localparam logic [DW-1:0] DEPTH_W = DW'(TABLE_DEPTH);

    logic [mepc_pkg::COMP_W-1:0]   r_comp_base;
    logic [mepc_pkg::EDGE_W-1:0]   r_edge_base;

    logic                          r_busy;
    logic                          n_busy;
    mepc_pkg::t_item               r_item;
    logic [AW-1:0]                 r_slot;

    logic                          r_out_valid;
    mepc_pkg::t_result             r_out;

    logic                          in_accept;
    logic                          out_free;
    logic                          done;
    logic                          clearing;
    logic                          cfg_write;
    logic [DW-1:0]                 diff;
    logic                          in_range;
    logic [AW-1:0]                 slot;

    mepc_pkg::t_entry              rd_entry;
    mepc_pkg::t_entry              wr_data;
    mepc_pkg::t_result             result;
    logic                          upd_we;

    assign cfg_write = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp_base <= '0;
            r_edge_base <= '0;
        end else if (cfg_write) begin
            case (i_paddr[2])
                mepc_pkg::REG_COMP_BASE: r_comp_base <= i_pwdata[mepc_pkg::COMP_W-1:0];
                mepc_pkg::REG_EDGE_BASE: r_edge_base <= i_pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            mepc_pkg::REG_COMP_BASE:
                o_prdata = {{(mepc_pkg::DATA_W - mepc_pkg::COMP_W){1'b0}}, r_comp_base};
            mepc_pkg::REG_EDGE_BASE: o_prdata = r_edge_base;
            default:                 o_prdata = '0;
        endcase
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign done       = r_busy && out_free;
    assign o_in_stall = clearing || (r_busy && !out_free);
    assign in_accept  = i_in_valid && !o_in_stall;

    assign diff     = {1'b0, i_src_comp} - {1'b0, r_comp_base};
    assign in_range = !diff[DW-1] && ({1'b0, diff[DW-2:0]} < DEPTH_W);
    assign slot     = diff[AW-1:0];

    assign n_busy = in_accept ? 1'b1 : (done ? 1'b0 : r_busy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.op        <= i_op;
            r_item.range_err <= !in_range;
            r_item.self_loop <= (i_src_comp == i_dst_comp);
            r_item.dst       <= i_dst_comp;
            r_item.weight    <= i_weight;
            r_item.edge_id   <= i_edge_index + r_edge_base;
            r_slot           <= slot;
        end
    end

    mepc_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_accept && in_range),
        .i_rd_addr  (slot),
        .i_wr_en    (done && upd_we),
        .i_wr_addr  (r_slot),
        .i_wr_data  (wr_data),
        .o_rd_data  (rd_entry),
        .o_clearing (clearing)
    );

    mepc_update u_update (
        .i_item    (r_item),
        .i_entry   (rd_entry),
        .o_result  (result),
        .o_wr_en   (upd_we),
        .o_wr_data (wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kept        = r_out.kept;
    assign o_range_error = r_out.range_error;
    assign o_entry_valid = r_out.entry_valid;
    assign o_best_target = r_out.best_target;
    assign o_best_edge   = r_out.best_edge;
    assign o_best_weight = r_out.best_weight;

endmodule

// ----- rtl/mepc_checker.sv -----
module mepc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_kept,
    input logic                          o_range_error,
    input logic                          o_entry_valid,
    input logic [mepc_pkg::COMP_W-1:0]   o_best_target,
    input logic [mepc_pkg::EDGE_W-1:0]   o_best_edge,
    input logic [mepc_pkg::WEIGHT_W-1:0] o_best_weight
);

    // The table clears itself after reset, so input words are held off.
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled during table clear");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kept)
            && $stable(o_range_error) && $stable(o_entry_valid)
            && $stable(o_best_target) && $stable(o_best_edge) && $stable(o_best_weight))
        else $error("stalled result word changed");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_kept, o_range_error, o_entry_valid}))
        else $error("result flags conflict");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_entry_valid |->
            (o_best_target == '0) && (o_best_edge == '0) && (o_best_weight == '0))
        else $error("entry fields set without a valid entry");

endmodule

bind min_edge_per_component mepc_checker u_mepc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_kept        (o_kept),
    .o_range_error (o_range_error),
    .o_entry_valid (o_entry_valid),
    .o_best_target (o_best_target),
    .o_best_edge   (o_best_edge),
    .o_best_weight (o_best_weight)
);

// ----- tb/sv/tb_min_edge_per_component.sv -----
module tb_min_edge_per_component;

    typedef logic [mepc_pkg::COMP_W-1:0]   t_label;
    typedef logic [mepc_pkg::WEIGHT_W-1:0] t_weight;

    localparam logic [mepc_pkg::WEIGHT_W-1:0] W_ZERO = 31'h0000_0000;
    localparam logic [mepc_pkg::WEIGHT_W-1:0] W_INF  = 31'h7F80_0000;
    localparam logic [mepc_pkg::WEIGHT_W-1:0] W_QNAN = 31'h7FC0_0000;
    localparam logic [mepc_pkg::WEIGHT_W-1:0] W_MAX  = 31'h7FFF_FFFF;
    localparam logic [mepc_pkg::COMP_W-1:0]   LABEL_MAX = 20'hF_FFFF;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_op;
    logic [mepc_pkg::COMP_W-1:0]   i_src_comp;
    logic [mepc_pkg::COMP_W-1:0]   i_dst_comp;
    logic [mepc_pkg::WEIGHT_W-1:0] i_weight;
    logic [mepc_pkg::EDGE_W-1:0]   i_edge_index;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic                          o_kept;
    logic                          o_range_error;
    logic                          o_entry_valid;
    logic [mepc_pkg::COMP_W-1:0]   o_best_target;
    logic [mepc_pkg::EDGE_W-1:0]   o_best_edge;
    logic [mepc_pkg::WEIGHT_W-1:0] o_best_weight;
    logic                          i_psel;
    logic                          i_penable;
    logic                          i_pwrite;
    logic [mepc_pkg::PADDR_W-1:0]  i_paddr;
    logic [mepc_pkg::DATA_W-1:0]   i_pwdata;
    logic [mepc_pkg::DATA_W-1:0]   o_prdata;
    logic                          o_pready;

    min_edge_per_component uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_src_comp    (i_src_comp),
        .i_dst_comp    (i_dst_comp),
        .i_weight      (i_weight),
        .i_edge_index  (i_edge_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kept        (o_kept),
        .o_range_error (o_range_error),
        .o_entry_valid (o_entry_valid),
        .o_best_target (o_best_target),
        .o_best_edge   (o_best_edge),
        .o_best_weight (o_best_weight),
        .i_psel        (i_psel),
        .i_penable     (i_penable),
        .i_pwrite      (i_pwrite),
        .i_paddr       (i_paddr),
        .i_pwdata      (i_pwdata),
        .o_prdata      (o_prdata),
        .o_pready      (o_pready)
    );

    logic [mepc_pkg::COMP_W-1:0]   win_base;
    logic [mepc_pkg::EDGE_W-1:0]   id_base;
    logic                          slot_used    [mepc_pkg::TABLE_DEPTH];
    logic                          slot_written [mepc_pkg::TABLE_DEPTH];
    logic [mepc_pkg::COMP_W-1:0]   slot_target  [mepc_pkg::TABLE_DEPTH];
    logic [mepc_pkg::EDGE_W-1:0]   slot_edge    [mepc_pkg::TABLE_DEPTH];
    logic [mepc_pkg::WEIGHT_W-1:0] slot_weight  [mepc_pkg::TABLE_DEPTH];

    mepc_pkg::t_result awaited_results[$];
    mepc_pkg::t_result got_word;
    mepc_pkg::t_result want_word;
    int      errors;
    int      burst_left;
    int      stall_mode;
    int      stall_count;

    always #10 i_clk = ~i_clk;

    function automatic mepc_pkg::t_result lightest_edge_step(
        input logic                          op,
        input logic [mepc_pkg::COMP_W-1:0]   src,
        input logic [mepc_pkg::COMP_W-1:0]   dst,
        input logic [mepc_pkg::WEIGHT_W-1:0] w,
        input logic [mepc_pkg::EDGE_W-1:0]   idx
    );
        mepc_pkg::t_result res;
        int unsigned       slot;
        res = '0;
        if (src < win_base || int'(src - win_base) >= int'(mepc_pkg::TABLE_DEPTH)) begin
            res.range_error = 1'b1;
            return res;
        end
        slot = 32'(src - win_base);
        if (op == mepc_pkg::OP_OFFER) begin
            if (src != dst) begin
                res.kept = 1'b1;
                if (!slot_used[slot] || w < slot_weight[slot]) begin
                    slot_used[slot]    = 1'b1;
                    slot_written[slot] = 1'b1;
                    slot_target[slot]  = dst;
                    slot_edge[slot]    = idx + id_base;
                    slot_weight[slot]  = w;
                end
            end
        end else begin
            if (slot_used[slot]) begin
                res.entry_valid = 1'b1;
                res.best_target = slot_target[slot];
                res.best_edge   = slot_edge[slot];
                res.best_weight = slot_weight[slot];
            end
            slot_used[slot] = 1'b0;
        end
        return res;
    endfunction

    task automatic send_word(
        input logic                          op,
        input logic [mepc_pkg::COMP_W-1:0]   src,
        input logic [mepc_pkg::COMP_W-1:0]   dst,
        input logic [mepc_pkg::WEIGHT_W-1:0] w,
        input logic [mepc_pkg::EDGE_W-1:0]   idx
    );
        int                gap;
        mepc_pkg::t_result want;
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_src_comp   <= src;
        i_dst_comp   <= dst;
        i_weight     <= w;
        i_edge_index <= idx;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        want = lightest_edge_step(op, src, dst, w, idx);
        awaited_results = {awaited_results, want};
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic offer(
        input logic [mepc_pkg::COMP_W-1:0]   src,
        input logic [mepc_pkg::COMP_W-1:0]   dst,
        input logic [mepc_pkg::WEIGHT_W-1:0] w,
        input logic [mepc_pkg::EDGE_W-1:0]   idx
    );
        send_word(mepc_pkg::OP_OFFER, src, dst, w, idx);
    endtask

    task automatic read_entry(input logic [mepc_pkg::COMP_W-1:0] src);
        send_word(mepc_pkg::OP_READ, src, t_label'($urandom), t_weight'($urandom), $urandom);
    endtask

    task automatic apb_access(
        input  logic                         wr,
        input  logic [mepc_pkg::PADDR_W-1:0] addr,
        input  logic [mepc_pkg::DATA_W-1:0]  wdata,
        output logic [mepc_pkg::DATA_W-1:0]  rdata
    );
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= wr;
        i_paddr   <= addr;
        i_pwdata  <= wdata;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (o_pready !== 1'b1);
        rdata = o_prdata;
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(
        input logic [mepc_pkg::PADDR_W-1:0] addr,
        input logic [mepc_pkg::DATA_W-1:0]  value
    );
        logic [mepc_pkg::DATA_W-1:0] rdata;
        apb_access(1'b1, addr, value, rdata);
        apb_access(1'b0, addr, '0, rdata);
        if (rdata !== value) begin
            $display("%0t: register %0d readback expected %h actual %h",
                     $time, addr, value, rdata);
            errors++;
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [mepc_pkg::COMP_W-1:0] cbase,
                              input logic [mepc_pkg::EDGE_W-1:0] ebase);
        wait_idle();
        check_register({mepc_pkg::REG_COMP_BASE, 2'b00}, {12'd0, cbase});
        win_base = cbase;
        check_register({mepc_pkg::REG_EDGE_BASE, 2'b00}, ebase);
        id_base = ebase;
    endtask

    task automatic test_tie_and_replace();
        set_window('0, 32'hFFFF_FFF0);
        offer(20'd5, 20'd9, 31'd100, 32'h20);
        offer(20'd5, 20'd7, 31'd100, 32'd1);
        offer(20'd5, 20'd8, 31'd99, 32'd2);
        offer(20'd5, 20'd3, W_MAX, 32'd3);
        read_entry(20'd5);
        read_entry(20'd5);
        offer(20'd1, 20'd2, W_ZERO, 32'd10);
        offer(20'd1, 20'd3, W_ZERO, 32'd11);
        read_entry(20'd1);
    endtask

    task automatic test_self_loop_and_extremes();
        offer(20'd7, 20'd7, 31'd1, 32'd4);
        offer(20'd0, LABEL_MAX, W_ZERO, 32'hFFFF_FFFF);
        offer(20'd1023, 20'd0, W_MAX, 32'd0);
        offer(20'd1023, 20'd1, W_QNAN, 32'hAAAA_5555);
        offer(20'd1023, 20'd2, W_INF, 32'h5555_AAAA);
        read_entry(20'd0);
        read_entry(20'd1023);
    endtask

    task automatic test_range_error();
        offer(20'd1024, 20'd3, 31'd1, 32'd1);
        read_entry(20'd1024);
        offer(LABEL_MAX, 20'd0, 31'd1, 32'd1);
        set_window(LABEL_MAX, 32'hFFFF_FFFF);
        offer(LABEL_MAX, 20'd0, 31'd5, 32'd1);
        offer(20'hF_FFFE, 20'd0, 31'd5, 32'd1);
        read_entry(20'd0);
        read_entry(LABEL_MAX);
        read_entry(LABEL_MAX);
    endtask

    task automatic run_traffic(input int count, input int span);
        int                            kind;
        int                            limit;
        int                            slot;
        int unsigned                   top;
        logic [mepc_pkg::COMP_W-1:0]   src;
        logic [mepc_pkg::COMP_W-1:0]   dst;
        logic [mepc_pkg::WEIGHT_W-1:0] w;
        limit = span;
        if (int'(win_base) + span > 'h10_0000) limit = 'h10_0000 - int'(win_base);
        top = int'(win_base) + mepc_pkg::TABLE_DEPTH;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 99);
            slot = $urandom_range(0, limit - 1);
            src  = win_base + t_label'(slot);
            if (kind >= 85) begin
                if (win_base != 0 && ($urandom_range(0, 1) == 0 || top > 'hF_FFFF)) begin
                    src = t_label'($urandom_range(0, int'(win_base) - 1));
                end else begin
                    src = t_label'($urandom_range(top, 'hF_FFFF));
                end
                send_word(1'($urandom_range(0, 1)), src, t_label'($urandom),
                          t_weight'($urandom), $urandom);
            end else if (kind >= 60 && slot_written[slot]) begin
                read_entry(src);
            end else begin
                dst = ($urandom_range(0, 9) == 0) ? src : t_label'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: w = t_weight'($urandom_range(0, 15));
                    9: begin
                        case ($urandom_range(0, 3))
                            0: w = W_ZERO;
                            1: w = W_INF;
                            2: w = W_QNAN;
                            default: w = W_MAX;
                        endcase
                    end
                    default: w = t_weight'($urandom);
                endcase
                offer(src, dst, w, $urandom);
            end
        end
    endtask

    task automatic test_random_traffic();
        set_window('0, '0);
        run_traffic(500, 64);
        set_window(t_label'($urandom_range(0, 'hF_FFFF)), $urandom);
        run_traffic(500, 1024);
        set_window(20'hF_FC00, 32'hFFFF_FFFF);
        run_traffic(450, 256);
        set_window(20'hF_FF00, 32'h8000_0000);
        run_traffic(450, 1024);
    endtask

    always @(posedge i_clk) begin
        if (stall_count == 0) begin
            stall_mode  = $urandom_range(0, 2);
            stall_count = $urandom_range(20, 200);
        end
        stall_count--;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: i_out_stall <= (stall_count % 11) < 6;
        endcase
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got_word = {o_kept, o_range_error, o_entry_valid,
                        o_best_target, o_best_edge, o_best_weight};
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual %h",
                         $time, got_word);
                errors++;
            end else begin
                want_word = awaited_results.pop_front();
                compare_field("kept", 32'(want_word.kept), 32'(got_word.kept));
                compare_field("range_error", 32'(want_word.range_error),
                              32'(got_word.range_error));
                compare_field("entry_valid", 32'(want_word.entry_valid),
                              32'(got_word.entry_valid));
                compare_field("best_target", 32'(want_word.best_target),
                              32'(got_word.best_target));
                compare_field("best_edge", want_word.best_edge, got_word.best_edge);
                compare_field("best_weight", 32'(want_word.best_weight),
                              32'(got_word.best_weight));
            end
        end
    end

    initial begin
        #(20 * 400000);
        $display("tb_min_edge_per_component failed");
        $finish;
    end

    initial begin
        i_clk        = 1'b0;
        errors       = 0;
        burst_left   = 0;
        stall_mode   = 0;
        stall_count  = 0;
        win_base     = '0;
        id_base      = '0;
        foreach (slot_used[k]) begin
            slot_used[k]    = 1'b0;
            slot_written[k] = 1'b0;
        end
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_out_stall  <= 1'b0;
        i_op         <= mepc_pkg::OP_OFFER;
        i_src_comp   <= '0;
        i_dst_comp   <= '0;
        i_weight     <= '0;
        i_edge_index <= '0;
        i_psel       <= 1'b0;
        i_penable    <= 1'b0;
        i_pwrite     <= 1'b0;
        i_paddr      <= '0;
        i_pwdata     <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_tie_and_replace();
        test_self_loop_and_extremes();
        test_range_error();
        test_random_traffic();

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_min_edge_per_component passed");
        end else begin
            $display("tb_min_edge_per_component failed");
        end
        $finish;
    end

endmodule

// ----- min_edge_per_component.f -----
rtl/mepc_pkg.sv
rtl/mepc_table.sv
rtl/mepc_update.sv
rtl/min_edge_per_component.sv
rtl/mepc_checker.sv
tb/sv/tb_min_edge_per_component.sv
